>>> src/scalu_pkg.sv
package scalu_pkg;

  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 5;
  localparam int UA_W    = 5;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic [DEPTH_W-1:0]       depth;
    logic [1:0]               status;
  } rsp_t;

  // operation codes
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // microcode addresses
  localparam logic [UA_W-1:0] UA_IDLE      = 5'd0;
  localparam logic [UA_W-1:0] UA_PUSH_CHK  = 5'd1;
  localparam logic [UA_W-1:0] UA_PUSH_WR   = 5'd2;
  localparam logic [UA_W-1:0] UA_POP_CHK   = 5'd3;
  localparam logic [UA_W-1:0] UA_POP_RD    = 5'd4;
  localparam logic [UA_W-1:0] UA_POP_LD    = 5'd5;
  localparam logic [UA_W-1:0] UA_AR_CHK    = 5'd6;
  localparam logic [UA_W-1:0] UA_AR_RDB    = 5'd7;
  localparam logic [UA_W-1:0] UA_AR_LDB    = 5'd8;
  localparam logic [UA_W-1:0] UA_AR_EXEC   = 5'd9;
  localparam logic [UA_W-1:0] UA_AR_WB     = 5'd10;
  localparam logic [UA_W-1:0] UA_DIV_CHK   = 5'd11;
  localparam logic [UA_W-1:0] UA_DIV_STEP  = 5'd12;
  localparam logic [UA_W-1:0] UA_DIV_FIX   = 5'd13;
  localparam logic [UA_W-1:0] UA_ERR_OVER  = 5'd14;
  localparam logic [UA_W-1:0] UA_ERR_UNDER = 5'd15;
  localparam logic [UA_W-1:0] UA_ERR_DIVZ  = 5'd16;
  localparam logic [UA_W-1:0] UA_EMIT      = 5'd17;
  localparam logic [UA_W-1:0] UA_NOP       = 5'd18;

  // jump conditions
  typedef enum logic [3:0] {
    JC_NEXT     = 4'd0,
    JC_ALWAYS   = 4'd1,
    JC_FULL     = 4'd2,
    JC_EMPTY    = 4'd3,
    JC_LT2      = 4'd4,
    JC_DIV_OP   = 4'd5,
    JC_BZERO    = 4'd6,
    JC_DIV_BUSY = 4'd7,
    JC_WAIT_CMD = 4'd8,
    JC_WAIT_RSP = 4'd9
  } jc_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_TOP  = 2'd1,
    RD_NEXT = 2'd2
  } rd_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_PUSH = 2'd1,
    WR_RES  = 2'd2
  } wr_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_t;

  typedef enum logic [2:0] {
    R_HOLD  = 3'd0,
    R_VALUE = 3'd1,
    R_MEM   = 3'd2,
    R_ARITH = 3'd3,
    R_QUO   = 3'd4,
    R_ZERO  = 3'd5
  } rsel_t;

  typedef enum logic [1:0] {
    DV_NONE = 2'd0,
    DV_INIT = 2'd1,
    DV_STEP = 2'd2
  } dv_t;

  typedef struct packed {
    jc_t             jc;
    logic [UA_W-1:0] tgt;
    rd_t             rd;
    wr_t             wr;
    cnt_t            cnt;
    rsel_t           rsel;
    logic            ld_a;
    logic            ld_b;
    dv_t             dv;
    logic            st_ld;
    logic [1:0]      st;
  } ucw_t;

  // control store
  function automatic ucw_t ucode(input logic [UA_W-1:0] addr);
    ucw_t w;
    w = '0;
    unique case (addr)
      UA_IDLE: begin
        w.jc = JC_WAIT_CMD;
      end
      UA_PUSH_CHK: begin
        w.jc  = JC_FULL;
        w.tgt = UA_ERR_OVER;
      end
      UA_PUSH_WR: begin
        w.jc    = JC_ALWAYS;
        w.tgt   = UA_EMIT;
        w.wr    = WR_PUSH;
        w.cnt   = CNT_INC;
        w.rsel  = R_VALUE;
        w.st_ld = 1'b1;
        w.st    = ST_OK;
      end
      UA_POP_CHK: begin
        w.jc  = JC_EMPTY;
        w.tgt = UA_ERR_UNDER;
      end
      UA_POP_RD: begin
        w.rd  = RD_TOP;
        w.cnt = CNT_DEC;
      end
      UA_POP_LD: begin
        w.jc    = JC_ALWAYS;
        w.tgt   = UA_EMIT;
        w.rsel  = R_MEM;
        w.st_ld = 1'b1;
        w.st    = ST_OK;
      end
      UA_AR_CHK: begin
        w.jc  = JC_LT2;
        w.tgt = UA_ERR_UNDER;
        w.rd  = RD_TOP;
      end
      UA_AR_RDB: begin
        w.rd   = RD_NEXT;
        w.ld_a = 1'b1;
      end
      UA_AR_LDB: begin
        w.ld_b = 1'b1;
      end
      UA_AR_EXEC: begin
        w.jc   = JC_DIV_OP;
        w.tgt  = UA_DIV_CHK;
        w.rsel = R_ARITH;
      end
      UA_AR_WB: begin
        w.jc    = JC_ALWAYS;
        w.tgt   = UA_EMIT;
        w.wr    = WR_RES;
        w.cnt   = CNT_DEC;
        w.st_ld = 1'b1;
        w.st    = ST_OK;
      end
      UA_DIV_CHK: begin
        w.jc  = JC_BZERO;
        w.tgt = UA_ERR_DIVZ;
        w.dv  = DV_INIT;
      end
      UA_DIV_STEP: begin
        w.jc  = JC_DIV_BUSY;
        w.tgt = UA_DIV_STEP;
        w.dv  = DV_STEP;
      end
      UA_DIV_FIX: begin
        w.jc   = JC_ALWAYS;
        w.tgt  = UA_AR_WB;
        w.rsel = R_QUO;
      end
      UA_ERR_OVER: begin
        w.jc    = JC_ALWAYS;
        w.tgt   = UA_EMIT;
        w.rsel  = R_ZERO;
        w.st_ld = 1'b1;
        w.st    = ST_OVER;
      end
      UA_ERR_UNDER: begin
        w.jc    = JC_ALWAYS;
        w.tgt   = UA_EMIT;
        w.rsel  = R_ZERO;
        w.st_ld = 1'b1;
        w.st    = ST_UNDER;
      end
      UA_ERR_DIVZ: begin
        w.jc    = JC_ALWAYS;
        w.tgt   = UA_EMIT;
        w.rsel  = R_ZERO;
        w.st_ld = 1'b1;
        w.st    = ST_DIVZ;
      end
      UA_EMIT: begin
        w.jc  = JC_WAIT_RSP;
        w.tgt = UA_IDLE;
      end
      UA_NOP: begin
        w.jc    = JC_ALWAYS;
        w.tgt   = UA_EMIT;
        w.rsel  = R_ZERO;
        w.st_ld = 1'b1;
        w.st    = ST_OK;
      end
      default: begin
        w.jc  = JC_ALWAYS;
        w.tgt = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> src/stack_calculator_alu_core.sv
// Each command runs as a microcode sequence that ends in the emit step; a divide adds
// the divide check, the shift-subtract loop and a sign fix before the write-back.
// The shift-subtract loop produces one quotient bit a step.
// One command is worked at a time by the microcode sequencer; a stalled response
// holds the sequencer in the emit step and so blocks acceptance of the next command.
// Synchronous reset empties the stack and clears the sequencer and response valid.
module stack_calculator_alu_core #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  scalu_pkg::cmd_t cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output scalu_pkg::rsp_t rsp
);
  import scalu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [UA_W-1:0]   upc;
  logic [UA_W-1:0]   upc_next;
  logic [UA_W-1:0]   dispatch;
  ucw_t              uw;

  logic [2:0]        op_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] res_q;
  logic [1:0]        st_q;

  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dsr;
  logic [4:0]        dcnt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] quo_signed;
  logic [DATA_W-1:0] arith_res;

  logic              cmd_acc;
  logic              rsp_free;
  logic              full;

  assign uw        = ucode(upc);
  assign cmd_stall = (upc != UA_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign full      = (count == CW'(DEPTH));
  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);

  always_comb begin
    case (cmd.op) inside
      OP_PUSH:                       dispatch = UA_PUSH_CHK;
      OP_POP:                        dispatch = UA_POP_CHK;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: dispatch = UA_AR_CHK;
      default:                       dispatch = UA_NOP;
    endcase
  end

  // sequencer
  always_comb begin
    upc_next = upc + UA_W'(1);
    unique case (uw.jc)
      JC_NEXT:     upc_next = upc + UA_W'(1);
      JC_ALWAYS:   upc_next = uw.tgt;
      JC_FULL:     if (full) upc_next = uw.tgt;
      JC_EMPTY:    if (count == '0) upc_next = uw.tgt;
      JC_LT2:      if (count < CW'(2)) upc_next = uw.tgt;
      JC_DIV_OP:   if (op_q == OP_DIV) upc_next = uw.tgt;
      JC_BZERO:    if (b_q == '0) upc_next = uw.tgt;
      JC_DIV_BUSY: if (dcnt != '0) upc_next = uw.tgt;
      JC_WAIT_CMD: upc_next = cmd_acc ? dispatch : upc;
      JC_WAIT_RSP: upc_next = rsp_free ? uw.tgt : upc;
      default:     upc_next = UA_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      op_q  <= cmd.op;
      val_q <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (uw.cnt)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= cnt_m1;
        default: count <= count;
      endcase
    end
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    case (uw.wr)
      WR_PUSH: mem[count[AW-1:0]] <= val_q;
      WR_RES:  mem[cnt_m2[AW-1:0]] <= res_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (uw.rd)
      RD_TOP:  rd_q <= mem[cnt_m1[AW-1:0]];
      RD_NEXT: rd_q <= mem[cnt_m2[AW-1:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uw.ld_a) a_q <= rd_q;
    if (uw.ld_b) b_q <= rd_q;
  end

  always_comb begin
    case (op_q)
      OP_ADD:  arith_res = a_q + b_q;
      OP_SUB:  arith_res = a_q - b_q;
      OP_MUL:  arith_res = a_q * b_q;
      default: arith_res = a_q;
    endcase
  end

  // restoring divider on magnitudes, quotient bits shift into quo
  assign shifted    = {rem, quo[DATA_W-1]};
  assign diff       = shifted - {1'b0, dsr};
  assign quo_signed = (a_q[DATA_W-1] ^ b_q[DATA_W-1]) ? (~quo + DATA_W'(1)) : quo;

  always_ff @(posedge clk) begin
    case (uw.dv)
      DV_INIT: begin
        rem  <= '0;
        quo  <= a_q[DATA_W-1] ? (~a_q + DATA_W'(1)) : a_q;
        dsr  <= b_q[DATA_W-1] ? (~b_q + DATA_W'(1)) : b_q;
        dcnt <= '1;
      end
      DV_STEP: begin
        if (!diff[DATA_W]) begin
          rem <= diff[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        dcnt <= dcnt - 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (uw.rsel)
      R_VALUE: res_q <= val_q;
      R_MEM:   res_q <= rd_q;
      R_ARITH: res_q <= arith_res;
      R_QUO:   res_q <= quo_signed;
      R_ZERO:  res_q <= '0;
      default: ;
    endcase
    if (uw.st_ld) st_q <= uw.st;
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (uw.jc == JC_WAIT_RSP && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.jc == JC_WAIT_RSP && rsp_free) begin
      rsp.result <= res_q;
      rsp.depth  <= DEPTH_W'(count);
      rsp.status <= st_q;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stack count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CW'(1) || count == $past(count) - CW'(1)))
    else $error("stack count moved by more than one");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> upc != UA_IDLE)
    else $error("accepted transaction not dispatched");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> rsp.result == '0)
    else $error("error response with nonzero result");

endmodule
